FILE: hdl/hall_six_step_commutator_macros.svh
// Assertion macros for the six-step Hall commutator.
// Expects i_clk and i_rst_n in the scope of the module that includes it.
`ifndef HALL_SIX_STEP_COMMUTATOR_MACROS_SVH
`define HALL_SIX_STEP_COMMUTATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define HSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hss_pkg.sv
// Shared types, codes and commutation tables for the six-step Hall commutator.
// No dependencies.
package hss_pkg;

    localparam int MOTOR_W = 2;
    localparam int HALL_W  = 3;
    localparam int DUTY_W  = 10;
    localparam int CNT_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;
    localparam int NUM_DUTY_REGS = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 3'd0,
        CFG_REVERSE = 3'd1,
        CFG_DUTY0   = 3'd2,
        CFG_DUTY1   = 3'd3,
        CFG_DUTY2   = 3'd4
    } t_cfg_idx;

    localparam logic ACT_HALL  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [HALL_W-1:0] HALL_ALL_LOW  = 3'd0;
    localparam logic [HALL_W-1:0] HALL_ALL_HIGH = 3'd7;
    localparam logic [HALL_W:0]   HALL_NONE     = 4'hF;

    typedef struct packed {
        logic [2:0]        high;
        logic [2:0]        low;
        logic [DUTY_W-1:0] duty;
        logic              updated;
        logic              fault;
        logic [CNT_W-1:0]  comm;
        logic [CNT_W-1:0]  err;
    } t_lane_res;

    // forward sequence; reverse swaps the high and low tables
    function automatic logic [2:0] fwd_high(input logic [HALL_W-1:0] h);
        logic [2:0] r;
        case (h)
            3'd1:    r = 3'b001;
            3'd2:    r = 3'b100;
            3'd3:    r = 3'b100;
            3'd4:    r = 3'b010;
            3'd5:    r = 3'b001;
            3'd6:    r = 3'b010;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] fwd_low(input logic [HALL_W-1:0] h);
        logic [2:0] r;
        case (h)
            3'd1:    r = 3'b010;
            3'd2:    r = 3'b001;
            3'd3:    r = 3'b010;
            3'd4:    r = 3'b100;
            3'd5:    r = 3'b100;
            3'd6:    r = 3'b001;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/hall_six_step_commutator.sv
// A word taken on the slave side passes the input register, then the result register, to the master side.
// Throughput: one word per cycle while the master side is ready; per-motor state is
// updated in the result stage so back-to-back words for one motor see fresh state.
// Reset: synchronous, active low; clears valids, enables, counters, drives; last Hall to none.
// Depends on hss_pkg and hall_six_step_commutator_macros.svh.
`include "hall_six_step_commutator_macros.svh"

module hall_six_step_commutator #(
    parameter int MOTORS       = 3,
    parameter int DUTY_MAX     = 1023,
    parameter int DUTY_DEFAULT = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // motor[1:0], hall[4:2], zero pad
    input  logic                              i_s_tuser,   // action
    // master side
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // motor_out[1:0], high_side_mask[4:2], low_side_mask[7:5], drive_duty[17:8],
    // drive_updated[18], hall_fault[19], commutations[51:20], hall_error_total[83:52]
    output logic [87:0]                       o_m_tdata,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hss_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int NST = (MOTORS < 4) ? MOTORS : 4;
    localparam int DUTY_RST = (DUTY_DEFAULT > DUTY_MAX) ? DUTY_MAX : DUTY_DEFAULT;
    localparam logic [16:0] DUTY_CAP = 17'(DUTY_MAX);
    localparam int DW = hss_pkg::DUTY_W;
    localparam int CW = hss_pkg::CNT_W;

    // ---------------- configuration ----------------
    logic [2:0]    r_enable;
    logic [2:0]    r_reverse;
    logic [DW-1:0] r_duty [hss_pkg::NUM_DUTY_REGS];
    logic          cfg_wr;
    logic [DW-1:0] cfg_duty_sat;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign cfg_duty_sat = ({7'd0, i_cfg_data} > DUTY_CAP) ? DUTY_CAP[DW-1:0] : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= '0;
            r_reverse <= '0;
            for (int k = 0; k < hss_pkg::NUM_DUTY_REGS; k++) begin
                r_duty[k] <= DW'(DUTY_RST);
            end
        end else if (cfg_wr) begin
            case (i_cfg_index)
                hss_pkg::CFG_ENABLE:  r_enable  <= i_cfg_data[2:0];
                hss_pkg::CFG_REVERSE: r_reverse <= i_cfg_data[2:0];
                hss_pkg::CFG_DUTY0:   r_duty[0] <= cfg_duty_sat;
                hss_pkg::CFG_DUTY1:   r_duty[1] <= cfg_duty_sat;
                hss_pkg::CFG_DUTY2:   r_duty[2] <= cfg_duty_sat;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                            r_in_valid;
    logic                            r_in_action;
    logic [hss_pkg::MOTOR_W-1:0]     r_in_motor;
    logic [hss_pkg::HALL_W-1:0]      r_in_hall;
    logic                            r_out_valid;
    logic                            advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_action <= i_s_tuser;
            r_in_motor  <= i_s_tdata[1:0];
            r_in_hall   <= i_s_tdata[4:2];
        end
    end

    // ---------------- per-motor lanes ----------------
    hss_pkg::t_lane_res lane_res [NST];
    logic               enable_clear_wr;

    assign enable_clear_wr = cfg_wr && (i_cfg_index == hss_pkg::CFG_ENABLE);

    for (genvar g = 0; g < NST; g++) begin : g_lane
        logic [hss_pkg::HALL_W:0] r_last;
        logic [CW-1:0]            r_comm;
        logic [CW-1:0]            r_err;
        logic [2:0]               r_high;
        logic [2:0]               r_low;
        logic [DW-1:0]            r_cur_duty;
        logic [hss_pkg::HALL_W:0] n_last;
        logic [CW-1:0]            n_comm;
        logic [CW-1:0]            n_err;
        logic [2:0]               n_high;
        logic [2:0]               n_low;
        logic [DW-1:0]            n_cur_duty;
        logic                     upd;
        logic                     fault;
        logic                     hit;
        logic                     en;
        logic                     rev;
        logic [DW-1:0]            duty_src;
        logic                     cut;

        if (g < 3) begin : g_reg
            assign en       = r_enable[g];
            assign rev      = r_reverse[g];
            assign duty_src = r_duty[g];
            assign cut      = enable_clear_wr && r_enable[g] && !i_cfg_data[g];
        end else begin : g_noreg
            assign en       = 1'b0;
            assign rev      = 1'b0;
            assign duty_src = '0;
            assign cut      = 1'b0;
        end

        assign hit = advance && (r_in_motor == hss_pkg::MOTOR_W'(g));

        always_comb begin
            n_last     = r_last;
            n_comm     = r_comm;
            n_err      = r_err;
            n_high     = r_high;
            n_low      = r_low;
            n_cur_duty = r_cur_duty;
            upd        = 1'b0;
            fault      = 1'b0;
            if (hit) begin
                if (r_in_action == hss_pkg::ACT_CLEAR) begin
                    n_comm = '0;
                end else if (r_in_hall == hss_pkg::HALL_ALL_LOW ||
                             r_in_hall == hss_pkg::HALL_ALL_HIGH) begin
                    // last Hall left as is: returning to it keeps the drive off
                    fault      = 1'b1;
                    upd        = 1'b1;
                    n_err      = r_err + CW'(1);
                    n_high     = '0;
                    n_low      = '0;
                    n_cur_duty = '0;
                end else if ({1'b0, r_in_hall} != r_last) begin
                    upd    = 1'b1;
                    n_last = {1'b0, r_in_hall};
                    if (!en) begin
                        n_high     = '0;
                        n_low      = '0;
                        n_cur_duty = '0;
                    end else begin
                        n_comm     = r_comm + CW'(1);
                        n_high     = rev ? hss_pkg::fwd_low(r_in_hall)
                                         : hss_pkg::fwd_high(r_in_hall);
                        n_low      = rev ? hss_pkg::fwd_high(r_in_hall)
                                         : hss_pkg::fwd_low(r_in_hall);
                        n_cur_duty = duty_src;
                    end
                end
            end else if (cut) begin
                n_high     = '0;
                n_low      = '0;
                n_cur_duty = '0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_last     <= hss_pkg::HALL_NONE;
                r_comm     <= '0;
                r_err      <= '0;
                r_high     <= '0;
                r_low      <= '0;
                r_cur_duty <= '0;
            end else begin
                r_last     <= n_last;
                r_comm     <= n_comm;
                r_err      <= n_err;
                r_high     <= n_high;
                r_low      <= n_low;
                r_cur_duty <= n_cur_duty;
            end
        end

        assign lane_res[g] = '{high: n_high, low: n_low, duty: n_cur_duty,
                               updated: upd, fault: fault, comm: n_comm, err: n_err};
    end

    // ---------------- result register ----------------
    hss_pkg::t_lane_res res;
    hss_pkg::t_lane_res r_res;
    logic [hss_pkg::MOTOR_W-1:0] r_out_motor;

    // motor beyond the lanes gives an all-zero result; only the motor field is carried
    always_comb begin
        res = '0;
        for (int k = 0; k < NST; k++) begin
            if (r_in_motor == hss_pkg::MOTOR_W'(k)) begin
                res = lane_res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res       <= res;
            r_out_motor <= r_in_motor;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_res.err, r_res.comm, r_res.fault, r_res.updated,
                         r_res.duty, r_res.low, r_res.high, r_out_motor};

    // ---------------- checks ----------------
    `HSS_ASSERT_NOW(a_fault_drive_off,
        r_out_valid && r_res.fault,
        r_res.high == 3'd0 && r_res.low == 3'd0 && r_res.duty == '0 && r_res.updated,
        "Hall fault word with drive still on")
    `HSS_ASSERT_NOW(a_phase_pair,
        r_out_valid && r_res.high != 3'd0,
        $onehot(r_res.high) && $onehot(r_res.low) && (r_res.high & r_res.low) == 3'd0,
        "high and low phase masks not a single distinct pair")
    `HSS_ASSERT_NEXT(a_in_held,
        r_in_valid && !advance,
        r_in_valid,
        "pending input word lost while stalled")
    `HSS_ASSERT_NOW(a_out_of_range_zero,
        r_out_valid && (32'(r_out_motor) >= 32'(MOTORS)),
        r_res.comm == '0 && r_res.err == '0 && !r_res.updated,
        "word for absent motor carries state")

endmodule

FILE: tb/sv/tb_hall_six_step_commutator.sv
`timescale 1ns / 1ps
// Self-checking testbench for hall_six_step_commutator: a directed table, then random
// Hall traffic in three phases, checked word by word against a local predictor or typed rows.
// Depends on hss_pkg and the commutator RTL.
module tb_hall_six_step_commutator;

    localparam int          DUTY_TOP      = 1023;
    localparam logic [1:0]  MOTOR_OUTSIDE = 2'd3;
    localparam int          LIMIT_CYCLES  = 200000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          BATCH_WORDS   = 70;
    localparam int          BATCHES       = 5;

    // forward commutation; reverse swaps high and low
    localparam logic [2:0] FWD_HI [8] = '{3'd0, 3'd1, 3'd4, 3'd4, 3'd2, 3'd1, 3'd2, 3'd0};
    localparam logic [2:0] FWD_LO [8] = '{3'd0, 3'd2, 3'd1, 3'd2, 3'd4, 3'd4, 3'd1, 3'd0};
    // Hall order seen by a motor turning forward
    localparam logic [2:0] HALL_SEQ [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] err;
        logic [31:0] comm;
        logic        fault;
        logic        updated;
        logic [9:0]  duty;
        logic [2:0]  low;
        logic [2:0]  high;
        logic [1:0]  motor;
    } t_drive_word;

    typedef struct {
        bit                 is_reg;
        hss_pkg::t_cfg_idx  reg_idx;
        logic [9:0]         reg_val;
        logic               act;
        logic [1:0]         mot;
        logic [2:0]         hall;
        bit                 typed;
        t_drive_word        want;
    } t_dir_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [7:0]   s_data = '0;
    logic         s_user = 1'b0;
    logic         m_tready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [2:0]   cfg_idx = '0;
    logic [9:0]   cfg_data = '0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [87:0]  o_m_tdata;
    logic         o_cfg_ready;

    // predictor state
    logic [2:0]   en_mask, rev_mask;
    logic [9:0]   duty_reg [3];
    logic [3:0]   last_hall [3];
    logic [31:0]  comm_cnt [3];
    logic [31:0]  err_cnt [3];
    logic [2:0]   hi_mask [3];
    logic [2:0]   lo_mask [3];
    logic [9:0]   cur_duty [3];

    t_drive_word  pending_drive_q [$];
    t_dir_row     dir_tab [$];
    t_drive_word  got_w, want_w;
    int           fail_count = 0;
    int           cycle_cnt = 0;
    int           src_idle = 25;
    int           rcv_idle = 55;
    bit           hold_req = 1'b0;
    bit           hold_taken = 1'b0;
    int           hold_left = 0;
    int           seq_pos [4];
    logic [2:0]   prev_hall [4];

    hall_six_step_commutator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic void motor_off(int m);
        hi_mask[m]  = '0;
        lo_mask[m]  = '0;
        cur_duty[m] = '0;
    endfunction

    function automatic void clear_model();
        en_mask  = '0;
        rev_mask = '0;
        for (int m = 0; m < 3; m++) begin
            duty_reg[m]  = '0;
            last_hall[m] = hss_pkg::HALL_NONE;
            comm_cnt[m]  = '0;
            err_cnt[m]   = '0;
            motor_off(m);
        end
    endfunction

    function automatic void apply_reg_write(hss_pkg::t_cfg_idx idx, logic [9:0] v);
        case (idx)
            hss_pkg::CFG_ENABLE: begin
                // a motor losing its enable drops its drive straight away
                for (int m = 0; m < 3; m++)
                    if (en_mask[m] && !v[m]) motor_off(m);
                en_mask = v[2:0];
            end
            hss_pkg::CFG_REVERSE: rev_mask = v[2:0];
            hss_pkg::CFG_DUTY0, hss_pkg::CFG_DUTY1, hss_pkg::CFG_DUTY2:
                duty_reg[int'(idx) - int'(hss_pkg::CFG_DUTY0)] =
                    (v > DUTY_TOP) ? 10'(DUTY_TOP) : v;
            default: ;
        endcase
    endfunction

    function automatic t_drive_word commutate_predict(logic act, logic [1:0] mot,
                                                      logic [2:0] hall);
        t_drive_word w;
        int          m;
        w       = '0;
        w.motor = mot;
        if (mot == MOTOR_OUTSIDE) return w;
        m = mot;
        if (act == hss_pkg::ACT_CLEAR) begin
            comm_cnt[m] = '0;
        end else if (hall == hss_pkg::HALL_ALL_LOW || hall == hss_pkg::HALL_ALL_HIGH) begin
            // last Hall is left alone on a fault
            w.fault   = 1'b1;
            w.updated = 1'b1;
            err_cnt[m]++;
            motor_off(m);
        end else if ({1'b0, hall} != last_hall[m]) begin
            last_hall[m] = {1'b0, hall};
            w.updated    = 1'b1;
            if (!en_mask[m]) begin
                motor_off(m);
            end else begin
                comm_cnt[m]++;
                hi_mask[m]  = rev_mask[m] ? FWD_LO[hall] : FWD_HI[hall];
                lo_mask[m]  = rev_mask[m] ? FWD_HI[hall] : FWD_LO[hall];
                cur_duty[m] = duty_reg[m];
            end
        end
        w.high = hi_mask[m];
        w.low  = lo_mask[m];
        w.duty = cur_duty[m];
        w.comm = comm_cnt[m];
        w.err  = err_cnt[m];
        return w;
    endfunction

    function automatic void row_reg(hss_pkg::t_cfg_idx idx, logic [9:0] v);
        t_dir_row r;
        r         = '{reg_idx: hss_pkg::CFG_ENABLE, default: '0};
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = v;
        dir_tab.push_back(r);
    endfunction

    function automatic void row_item(logic act, logic [1:0] mot, logic [2:0] hall);
        t_dir_row r;
        r      = '{reg_idx: hss_pkg::CFG_ENABLE, default: '0};
        r.act  = act;
        r.mot  = mot;
        r.hall = hall;
        dir_tab.push_back(r);
    endfunction

    // typed rows all leave the drive off
    function automatic void row_typed(logic act, logic [1:0] mot, logic [2:0] hall,
                                      logic upd, logic flt, logic [31:0] comm,
                                      logic [31:0] err);
        t_dir_row r;
        r              = '{reg_idx: hss_pkg::CFG_ENABLE, default: '0};
        r.act          = act;
        r.mot          = mot;
        r.hall         = hall;
        r.typed        = 1'b1;
        r.want         = '0;
        r.want.motor   = mot;
        r.want.updated = upd;
        r.want.fault   = flt;
        r.want.comm    = comm;
        r.want.err     = err;
        dir_tab.push_back(r);
    endfunction

    // called just after a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic act, logic [1:0] mot, logic [2:0] hall, bit typed,
                             t_drive_word want);
        t_drive_word w;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= act;
        s_data  <= {3'b000, hall, mot};
        do @(posedge i_clk); while (!o_s_tready);
        w = commutate_predict(act, mot, hall);
        pending_drive_q.push_back(typed ? want : w);
        @(negedge i_clk);
    endtask

    task automatic write_reg(hss_pkg::t_cfg_idx idx, logic [9:0] v);
        s_valid <= 1'b0;
        while (pending_drive_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, v);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random();
        logic [1:0] m;
        logic [2:0] h;
        logic       a;
        int         r;
        m = ($urandom_range(99) < 4) ? MOTOR_OUTSIDE : 2'($urandom_range(2));
        a = hss_pkg::ACT_HALL;
        r = $urandom_range(99);
        if (r < 5) begin
            a = hss_pkg::ACT_CLEAR;
            h = 3'($urandom_range(7));
        end else if (r < 13) begin
            h = $urandom_range(1) ? hss_pkg::HALL_ALL_HIGH : hss_pkg::HALL_ALL_LOW;
        end else if (r < 28) begin
            h = prev_hall[m];
        end else if (r < 80) begin
            // step one place along the sequence, either way round
            seq_pos[m] = $urandom_range(3) != 0 ? (seq_pos[m] + 1) % 6
                                                : (seq_pos[m] + 5) % 6;
            h = HALL_SEQ[seq_pos[m]];
        end else begin
            h = 3'($urandom_range(6, 1));
        end
        if (a == hss_pkg::ACT_HALL) prev_hall[m] = h;
        send_item(a, m, h, 1'b0, '0);
    endtask

    function automatic logic [9:0] pick_reg_val(hss_pkg::t_cfg_idx idx, int phase,
                                                int batch);
        logic [9:0] top;
        top = (idx == hss_pkg::CFG_ENABLE || idx == hss_pkg::CFG_REVERSE) ? 10'd7
                                                                          : 10'(DUTY_TOP);
        if (phase == 0 && batch == 0) return top;
        if (phase == 0 && batch == 1) return (idx == hss_pkg::CFG_ENABLE) ? top : '0;
        if (idx == hss_pkg::CFG_ENABLE && $urandom_range(1)) return top;
        case ($urandom_range(3))
            0:       return '0;
            1:       return top;
            default: return 10'($urandom_range(int'(top)));
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got_w = o_m_tdata;
            if (pending_drive_q.size() == 0) begin
                $error("drive word with nothing pending, motor %0d", got_w.motor);
                fail_count++;
            end else begin
                want_w = pending_drive_q.pop_front();
                check_field("motor_out", want_w.motor, got_w.motor);
                check_field("high_side_mask", want_w.high, got_w.high);
                check_field("low_side_mask", want_w.low, got_w.low);
                check_field("drive_duty", want_w.duty, got_w.duty);
                check_field("drive_updated", want_w.updated, got_w.updated);
                check_field("hall_fault", want_w.fault, got_w.fault);
                check_field("commutations", want_w.comm, got_w.comm);
                check_field("hall_error_total", want_w.err, got_w.err);
                check_field("pad", want_w.pad, got_w.pad);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        clear_model();
        for (int m = 0; m < 4; m++) begin
            seq_pos[m]   = 0;
            prev_hall[m] = HALL_SEQ[0];
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // straight out of reset every motor is disabled
        row_typed(hss_pkg::ACT_HALL, 2'd0, 3'd1, 1'b1, 1'b0, 0, 0);
        row_typed(hss_pkg::ACT_HALL, 2'd0, hss_pkg::HALL_ALL_LOW, 1'b1, 1'b1, 0, 1);
        row_typed(hss_pkg::ACT_HALL, 2'd1, hss_pkg::HALL_ALL_HIGH, 1'b1, 1'b1, 0, 1);
        row_typed(hss_pkg::ACT_HALL, MOTOR_OUTSIDE, 3'd5, 1'b0, 1'b0, 0, 0);
        row_typed(hss_pkg::ACT_CLEAR, 2'd2, 3'd0, 1'b0, 1'b0, 0, 0);
        row_reg(hss_pkg::CFG_ENABLE, 10'd7);
        row_reg(hss_pkg::CFG_REVERSE, 10'd2);
        row_reg(hss_pkg::CFG_DUTY0, 10'(DUTY_TOP));
        row_reg(hss_pkg::CFG_DUTY1, 10'd1);
        row_reg(hss_pkg::CFG_DUTY2, 10'd0);
        // Hall already recorded while disabled: drive stays off
        row_typed(hss_pkg::ACT_HALL, 2'd0, 3'd1, 1'b0, 1'b0, 0, 1);
        row_item(hss_pkg::ACT_HALL, 2'd0, 3'd5);
        row_item(hss_pkg::ACT_HALL, 2'd0, 3'd5);
        row_item(hss_pkg::ACT_HALL, 2'd0, hss_pkg::HALL_ALL_HIGH);
        row_item(hss_pkg::ACT_HALL, 2'd0, 3'd5);
        row_item(hss_pkg::ACT_HALL, 2'd1, 3'd3);
        row_item(hss_pkg::ACT_HALL, 2'd1, 3'd2);
        row_item(hss_pkg::ACT_HALL, 2'd2, 3'd6);
        row_item(hss_pkg::ACT_CLEAR, 2'd1, 3'd7);
        row_item(hss_pkg::ACT_HALL, 2'd1, 3'd4);
        row_reg(hss_pkg::CFG_ENABLE, 10'd4);
        row_item(hss_pkg::ACT_CLEAR, 2'd1, 3'd0);
        row_item(hss_pkg::ACT_HALL, 2'd2, 3'd4);
        row_item(hss_pkg::ACT_HALL, 2'd2, 3'd2);
        row_typed(hss_pkg::ACT_HALL, MOTOR_OUTSIDE, hss_pkg::HALL_ALL_LOW, 1'b0, 1'b0, 0, 0);
        row_item(hss_pkg::ACT_HALL, 2'd0, 3'd6);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_reg)
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            else
                send_item(dir_tab[i].act, dir_tab[i].mot, dir_tab[i].hall,
                          dir_tab[i].typed, dir_tab[i].want);
        end

        for (int p = 0; p < 3; p++) begin
            src_idle = (p == 0) ? 25 : (p == 1) ? 55 : 0;
            rcv_idle = (p == 0) ? 55 : (p == 1) ? 25 : 0;
            for (int b = 0; b < BATCHES; b++) begin
                for (int k = 0; k < 5; k++)
                    write_reg(hss_pkg::t_cfg_idx'(k),
                              pick_reg_val(hss_pkg::t_cfg_idx'(k), p, b));
                // long back-pressure once the sender runs flat out
                if (p == 2 && b == 0) hold_req = 1'b1;
                repeat (BATCH_WORDS) send_random();
            end
        end

        s_valid <= 1'b0;
        while (pending_drive_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/hss_pkg.sv
hdl/hall_six_step_commutator.sv
tb/sv/tb_hall_six_step_commutator.sv
